// ===== rtl/cwsf_pkg.sv =====
// shared types and constants of the convolution window shift feeder
`timescale 1ns / 1ps
`default_nettype none

package cwsf_pkg;

  // row geometry
  localparam int ROW_ELEMENTS = 8;
  localparam int ELEMENT_BITS = 8;
  localparam int STRIDE_LEN   = 2 * ROW_ELEMENTS;
  localparam int ROW_BITS     = ROW_ELEMENTS * ELEMENT_BITS;
  localparam int IDX_BITS     = $clog2(ROW_ELEMENTS);
  localparam int POS_BITS     = 3;
  localparam int KERNEL_BITS  = 3;

  // kernels up to this width take the fill element from the row end
  localparam logic [KERNEL_BITS-1:0] SMALL_KERNEL_MAX = KERNEL_BITS'(3);

  // stream widths
  localparam int IN_FIELD_BITS  = KERNEL_BITS + ROW_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ROW_BITS;
  localparam int IN_TUSER_BITS  = 2;
  localparam int OUT_TUSER_BITS = 2;

  typedef logic [ELEMENT_BITS-1:0] elem_t;

  // one input request
  typedef struct packed {
    logic                   in_valid;
    logic [KERNEL_BITS-1:0] kernel_size;
    logic                   stride_mode;
    logic                   row_last;
    logic [ROW_BITS-1:0]    data_row;
  } in_item_t;

  // one result request
  typedef struct packed {
    logic                out_valid;
    logic                out_almost_last;
    logic                out_last;
    logic [ROW_BITS-1:0] out_row;
  } res_item_t;

endpackage

`default_nettype wire

// ===== rtl/cwsf_in_stage.sv =====
// input register stage of the feeder
`timescale 1ns / 1ps
`default_nettype none

module cwsf_in_stage import cwsf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     up_valid_i,
  output logic          up_ready_o,
  input  wire in_item_t up_item_i,
  output logic          down_valid_o,
  input  wire logic     down_ready_i,
  output in_item_t      down_item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // take a new request when empty or when the held one moves on
  assign up_ready_o = !valid_q || down_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (up_ready_o) begin
      valid_d = up_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      item_q <= up_item_i;
    end
  end

  assign down_valid_o = valid_q;
  assign down_item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/cwsf_window_core.sv =====
// window state and the single pass row logic
`timescale 1ns / 1ps
`default_nettype none

module cwsf_window_core import cwsf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire in_item_t item_i,
  output res_item_t     res_o
);

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ROW_ELEMENTS - 1);

  elem_t               shift_q  [ROW_ELEMENTS];
  elem_t               shift_d  [ROW_ELEMENTS];
  elem_t               stride_q [STRIDE_LEN];
  elem_t               stride_d [STRIDE_LEN];
  elem_t               stride_n [STRIDE_LEN];
  elem_t               data_el  [ROW_ELEMENTS];
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic                active_q, active_d;

  logic [KERNEL_BITS-1:0] k_eff;
  logic                   busy;
  logic [IDX_BITS-1:0]    pos_lim;
  logic [IDX_BITS:0]      small_sum;
  logic [IDX_BITS-1:0]    small_src;
  logic [IDX_BITS-1:0]    fill_src;
  logic                   almost;
  logic                   last;
  logic [ROW_BITS-1:0]    row_out;

  // unpack the input row
  always_comb begin
    for (int i = 0; i < ROW_ELEMENTS; i++) begin
      data_el[i] = item_i.data_row[i*ELEMENT_BITS +: ELEMENT_BITS];
    end
  end

  // kernel, activity and fill source
  always_comb begin
    k_eff     = (item_i.kernel_size == '0) ? KERNEL_BITS'(1) : item_i.kernel_size;
    busy      = active_q || item_i.in_valid;
    pos_lim   = ({1'b0, pos_q} > {1'b0, LAST_IDX}) ? LAST_IDX : IDX_BITS'(pos_q);
    small_sum = (IDX_BITS + 1)'(ROW_ELEMENTS - 2) + (IDX_BITS + 1)'(pos_q);
    small_src = (small_sum > {1'b0, LAST_IDX}) ? LAST_IDX : small_sum[IDX_BITS-1:0];
    fill_src  = (k_eff > SMALL_KERNEL_MAX) ? pos_lim : small_src;
  end

  // shifted row: load on the first position, else shift in one element
  always_comb begin
    if (pos_q == '0) begin
      for (int i = 0; i < ROW_ELEMENTS; i++) begin
        shift_d[i] = data_el[i];
      end
    end else begin
      for (int i = 0; i < ROW_ELEMENTS - 1; i++) begin
        shift_d[i] = shift_q[i+1];
      end
      shift_d[ROW_ELEMENTS-1] = data_el[fill_src];
    end
  end

  // interleaved stride buffer
  always_comb begin
    if (pos_q <= POS_BITS'(1)) begin
      for (int i = 0; i < ROW_ELEMENTS; i++) begin
        stride_n[2*i]   = shift_d[i];
        stride_n[2*i+1] = data_el[i];
      end
    end else begin
      for (int i = 0; i < STRIDE_LEN - 1; i++) begin
        stride_n[i] = stride_q[i+1];
      end
      stride_n[STRIDE_LEN-1] = data_el[pos_lim];
    end
    for (int i = 0; i < STRIDE_LEN; i++) begin
      if (item_i.row_last) begin
        stride_d[i] = '0;
      end else if (item_i.stride_mode) begin
        stride_d[i] = stride_n[i];
      end else begin
        stride_d[i] = stride_q[i];
      end
    end
  end

  // window flags and position
  always_comb begin
    almost = (k_eff >= KERNEL_BITS'(2)) && (pos_q == POS_BITS'(k_eff - KERNEL_BITS'(2)));
    last   = (pos_q == POS_BITS'(k_eff - KERNEL_BITS'(1)));
    if (last) begin
      pos_d    = '0;
      active_d = 1'b0;
    end else begin
      pos_d    = pos_q + POS_BITS'(1);
      active_d = 1'b1;
    end
  end

  // result row, zero on an idle request
  always_comb begin
    for (int i = 0; i < ROW_ELEMENTS; i++) begin
      row_out[i*ELEMENT_BITS +: ELEMENT_BITS] =
        item_i.stride_mode ? stride_n[2*i] : shift_d[i];
    end
    res_o.out_valid       = busy;
    res_o.out_almost_last = busy && almost;
    res_o.out_last        = busy && last;
    res_o.out_row         = busy ? row_out : '0;
  end

  // state update on every non idle request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROW_ELEMENTS; i++) begin
        shift_q[i] <= '0;
      end
      for (int i = 0; i < STRIDE_LEN; i++) begin
        stride_q[i] <= '0;
      end
      pos_q    <= '0;
      active_q <= 1'b0;
    end else if (fire_i && busy) begin
      shift_q  <= shift_d;
      stride_q <= stride_d;
      pos_q    <= pos_d;
      active_q <= active_d;
    end
  end

  // a window end returns to the idle position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.out_last |=> (pos_q == '0) && !active_q)
    else $error("window end did not clear position");

  // an idle request leaves the window state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !res_o.out_valid |=> $stable(pos_q) && $stable(active_q))
    else $error("idle request changed window state");

  // a closed window always sits at its first position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (pos_q == '0))
    else $error("closed window away from first position");

  // flags only come with a valid row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.out_last || res_o.out_almost_last) |-> res_o.out_valid)
    else $error("flag without valid row");

endmodule

`default_nettype wire

// ===== rtl/cwsf_out_stage.sv =====
// result register stage of the feeder
`timescale 1ns / 1ps
`default_nettype none

module cwsf_out_stage import cwsf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      up_valid_i,
  output logic           up_ready_o,
  input  wire res_item_t up_res_i,
  output logic           down_valid_o,
  input  wire logic      down_ready_i,
  output res_item_t      down_res_o
);

  logic      valid_q, valid_d;
  res_item_t res_q;

  // free when empty or when the held result is taken
  assign up_ready_o = !valid_q || down_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (up_ready_o) begin
      valid_d = up_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      res_q <= up_res_i;
    end
  end

  assign down_valid_o = valid_q;
  assign down_res_o   = res_q;

endmodule

`default_nettype wire

// ===== rtl/conv_window_shift_feeder.sv =====
// top level of the convolution window shift feeder
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per cycle when the output is not stalled and returns
// exactly one result request for each, in order. A request goes into an
// input register, the window logic (shifted row, interleaved stride
// buffer, kernel position) turns it into a result in one pass, and the
// result lands in an output register; the window state loop sets the
// rate of one request per cycle. An idle request (no open window,
// in_valid low) returns an all zero result.
// Input tdata carries kernel_size then data_row, tuser carries in_valid and
// stride_mode, tlast carries row_last. Output tdata carries out_row, tuser
// carries out_valid and out_almost_last, tlast carries out_last.
module conv_window_shift_feeder import cwsf_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // kernel_size [2:0], data_row [66:3], zero fill above
  input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  // in_valid [0], stride_mode [1]
  input  wire logic [IN_TUSER_BITS-1:0]  s_axis_tuser_i,
  input  wire logic                      s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // out_row [63:0]
  output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata_o,
  // out_valid [0], out_almost_last [1]
  output logic [OUT_TUSER_BITS-1:0]      m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);

  in_item_t  in_item;
  in_item_t  held_item;
  res_item_t core_res;
  res_item_t out_res;
  logic      held_valid;
  logic      out_ready;

  // unpack the stream request
  always_comb begin
    in_item.in_valid    = s_axis_tuser_i[0];
    in_item.stride_mode = s_axis_tuser_i[1];
    in_item.row_last    = s_axis_tlast_i;
    in_item.kernel_size = s_axis_tdata_i[KERNEL_BITS-1:0];
    in_item.data_row    = s_axis_tdata_i[KERNEL_BITS +: ROW_BITS];
  end

  cwsf_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_valid_i   (s_axis_tvalid_i),
    .up_ready_o   (s_axis_tready_o),
    .up_item_i    (in_item),
    .down_valid_o (held_valid),
    .down_ready_i (out_ready),
    .down_item_o  (held_item)
  );

  cwsf_window_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (held_valid && out_ready),
    .item_i (held_item),
    .res_o  (core_res)
  );

  cwsf_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_valid_i   (held_valid),
    .up_ready_o   (out_ready),
    .up_res_i     (core_res),
    .down_valid_o (m_axis_tvalid_o),
    .down_ready_i (m_axis_tready_i),
    .down_res_o   (out_res)
  );

  // pack the result request
  assign m_axis_tdata_o = out_res.out_row;
  assign m_axis_tuser_o = {out_res.out_almost_last, out_res.out_valid};
  assign m_axis_tlast_o = out_res.out_last;

endmodule

`default_nettype wire
